@@ rtl/core/ermds_pkg.sv @@
// ----------------------------------------------------------------------------
// ermds_pkg: shared types and constants of the echo range meter
// Request and result payload structs, register map codes and the segment pattern table.
// ----------------------------------------------------------------------------
package ermds_pkg;

    typedef struct packed {
        logic echo_level;
        logic tick_50us;
        logic tick_1ms;
    } in_item_t;

    typedef struct packed {
        logic        trigger_pulse;
        logic [7:0]  segment_bits;
        logic [3:0]  digit_enable_n;
        logic [13:0] distance_value;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_MIN_TICKS       = 2'd0,
        REG_MAX_TICKS       = 2'd1,
        REG_OVERRANGE_TICKS = 2'd2,
        REG_TIMEOUT_TICKS   = 2'd3
    } reg_index_t;

    localparam logic [15:0] MIN_TICKS_RST       = 16'd3;
    localparam logic [15:0] MAX_TICKS_RST       = 16'd500;
    localparam logic [15:0] OVERRANGE_TICKS_RST = 16'd760;
    localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd1000;

    localparam logic [15:0] COUNT_LIMIT    = 16'hFFFF;
    localparam logic [13:0] OVERRANGE_CODE = 14'd9999;
    localparam logic [15:0] OVERRANGE_BCD  = 16'h9999;

    // distance = count * 50 / 58 = count * 25 / 29, tracked one tick at a time
    localparam logic [5:0]  CONV_STEP  = 6'd25;
    localparam logic [5:0]  CONV_DIV   = 6'd29;

    localparam logic [3:0]  ENABLE_RST = 4'b1110;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'hDB;
            4'd1:    pat = 8'h50;
            4'd2:    pat = 8'h1F;
            4'd3:    pat = 8'h5D;
            4'd4:    pat = 8'hD4;
            4'd5:    pat = 8'hCD;
            4'd6:    pat = 8'hCF;
            4'd7:    pat = 8'hD8;
            4'd8:    pat = 8'hDF;
            4'd9:    pat = 8'hDD;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/core/echo_range_meter_with_digit_scan_core.sv @@
// ----------------------------------------------------------------------------
// echo_range_meter_with_digit_scan_core: echo ranger with digit scan
// Measures echo width in 50 us ticks, stores the distance and scans its four
// decimal digits onto a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  in       | in_valid/in_ready  | in_data  (echo level, tick strobes)
//  out      | out_valid/out_ready| out_data (trigger, segments, enables,
//           |                    |           distance)
//  config   | APB psel/penable   | paddr[3:0], pwdata/prdata 32 bits
//
//  One request per cycle unless the result stalls: an input register, one
//  pass of logic, a result register that loads as the request advances.
//  The distance quotient and its BCD digits advance with each tick, so no
//  divider or multiplier lies in the path.
//  rst_n clears all but the data registers; config takes its reset values.
//  A stalled result holds the pass; the input register then holds one more.
// ----------------------------------------------------------------------------
module echo_range_meter_with_digit_scan_core
    import ermds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [15:0] min_ticks_reg, max_ticks_reg, overrange_ticks_reg, timeout_ticks_reg;
    reg_index_t  cfg_index;
    logic        cfg_write;

    // pipeline
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      advance;

    // measurement state
    logic        echo_prev_reg, echo_prev_next;
    logic [15:0] count_reg, count_next;
    logic        busy_reg, busy_next;
    logic [4:0]  rem_reg, rem_next;
    logic [13:0] quot_reg, quot_next;
    logic [15:0] quot_bcd_reg, quot_bcd_next;
    logic [13:0] dist_reg, dist_next;
    logic [15:0] dist_bcd_reg, dist_bcd_next;
    logic [1:0]  scan_reg, scan_next;
    logic [7:0]  seg_reg, seg_next;
    logic [3:0]  enable_reg, enable_next;
    logic        trigger;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ticks_reg       <= MIN_TICKS_RST;
            max_ticks_reg       <= MAX_TICKS_RST;
            overrange_ticks_reg <= OVERRANGE_TICKS_RST;
            timeout_ticks_reg   <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_TICKS:       min_ticks_reg       <= pwdata[15:0];
                REG_MAX_TICKS:       max_ticks_reg       <= pwdata[15:0];
                REG_OVERRANGE_TICKS: overrange_ticks_reg <= pwdata[15:0];
                REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_MIN_TICKS:       prdata = {16'd0, min_ticks_reg};
            REG_MAX_TICKS:       prdata = {16'd0, max_ticks_reg};
            REG_OVERRANGE_TICKS: prdata = {16'd0, overrange_ticks_reg};
            REG_TIMEOUT_TICKS:   prdata = {16'd0, timeout_ticks_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // one pass over the held request
    // ------------------------------------------------------------------
    always_comb
    begin
        logic       rise, fall, step, carry;
        logic [5:0] rem_sum;
        logic       bcd_carry;
        logic [3:0] digit;
        logic [3:0] sel_digit;

        echo_prev_next = echo_prev_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        quot_bcd_next  = quot_bcd_reg;
        dist_next      = dist_reg;
        dist_bcd_next  = dist_bcd_reg;
        scan_next      = scan_reg;
        seg_next       = seg_reg;
        enable_next    = enable_reg;
        trigger        = 1'b0;
        rem_sum        = 6'd0;
        carry          = 1'b0;
        bcd_carry      = 1'b0;
        digit          = 4'd0;
        sel_digit      = 4'd0;

        rise = in_data_reg.echo_level && !echo_prev_reg;
        fall = !in_data_reg.echo_level && echo_prev_reg;

        // edge handling sees the count before this request's tick
        if (fall)
        begin
            if (count_reg > min_ticks_reg && count_reg < max_ticks_reg)
            begin
                dist_next     = quot_reg;
                dist_bcd_next = quot_bcd_reg;
            end
            else if (count_reg >= overrange_ticks_reg)
            begin
                dist_next     = OVERRANGE_CODE;
                dist_bcd_next = OVERRANGE_BCD;
            end
        end
        if (rise || fall)
        begin
            count_next    = 16'd0;
            busy_next     = 1'b0;
            rem_next      = 5'd0;
            quot_next     = 14'd0;
            quot_bcd_next = 16'd0;
        end
        echo_prev_next = in_data_reg.echo_level;

        // 50 us tick: count saturates, quotient follows count*25/29
        step = in_data_reg.tick_50us && (count_next != COUNT_LIMIT);
        if (step)
        begin
            count_next = count_next + 16'd1;
            rem_sum    = {1'b0, rem_next} + CONV_STEP;
            if (rem_sum >= CONV_DIV)
            begin
                rem_sum = rem_sum - CONV_DIV;
                carry   = 1'b1;
            end
            rem_next = rem_sum[4:0];
            // quotient held at the overrange code, which is all that is shown
            if (carry && quot_next != OVERRANGE_CODE)
            begin
                quot_next = quot_next + 14'd1;
                bcd_carry = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    digit = quot_bcd_next[i*4 +: 4];
                    if (bcd_carry)
                    begin
                        if (digit == 4'd9)
                        begin
                            digit = 4'd0;
                        end
                        else
                        begin
                            digit     = digit + 4'd1;
                            bcd_carry = 1'b0;
                        end
                    end
                    quot_bcd_next[i*4 +: 4] = digit;
                end
            end
        end
        if (in_data_reg.tick_50us && busy_next && count_next > timeout_ticks_reg)
            busy_next = 1'b0;

        // 1 ms tick: advance the digit scan
        if (in_data_reg.tick_1ms)
        begin
            scan_next   = scan_reg + 2'd1;
            sel_digit   = dist_bcd_next[{scan_next, 2'b00} +: 4];
            seg_next    = seg_pattern(sel_digit);
            enable_next = ~(4'b0001 << scan_next);
        end

        if (!busy_next)
        begin
            trigger   = 1'b1;
            busy_next = 1'b1;
        end

        out_data_next.trigger_pulse  = trigger;
        out_data_next.segment_bits   = seg_next;
        out_data_next.digit_enable_n = enable_next;
        out_data_next.distance_value = dist_next;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            echo_prev_reg <= 1'b0;
            count_reg     <= 16'd0;
            busy_reg      <= 1'b0;
            rem_reg       <= 5'd0;
            quot_reg      <= 14'd0;
            quot_bcd_reg  <= 16'd0;
            dist_reg      <= 14'd0;
            dist_bcd_reg  <= 16'd0;
            scan_reg      <= 2'd0;
            seg_reg       <= 8'd0;
            enable_reg    <= ENABLE_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                echo_prev_reg <= echo_prev_next;
                count_reg     <= count_next;
                busy_reg      <= busy_next;
                rem_reg       <= rem_next;
                quot_reg      <= quot_next;
                quot_bcd_reg  <= quot_bcd_next;
                dist_reg      <= dist_next;
                dist_bcd_reg  <= dist_bcd_next;
                scan_reg      <= scan_next;
                seg_reg       <= seg_next;
                enable_reg    <= enable_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> busy_reg)
        else $error("busy flag not set after a pass");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < CONV_DIV[4:0])
        else $error("conversion remainder out of range");

    a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        quot_reg <= OVERRANGE_CODE && dist_reg <= OVERRANGE_CODE)
        else $error("distance above overrange code");

    a_enable_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(~enable_reg))
        else $error("digit enable not one-cold");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

@@ tb/sv/tb_echo_range_meter_with_digit_scan_core.sv @@
// ----------------------------------------------------------------------------
// tb_echo_range_meter_with_digit_scan_core: self-checking bench for the ranger
// Drives echo and tick requests with random gaps and result back-pressure.
// A per-request model gives the results but the hand-written ones. The register
// settings cover the reset values, the extremes and small thresholds. Echo
// pulse widths sit on and around each threshold.
// ----------------------------------------------------------------------------
module tb_echo_range_meter_with_digit_scan_core;
    import ermds_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned DIST_SCALE  = 50;
    localparam int unsigned SOUND_DIV   = 58;
    localparam int unsigned DRAIN_WAIT  = 4;
    // segment patterns of digits 9 down to 0
    localparam logic [79:0] GLYPHS = {8'hDD, 8'hDF, 8'hD8, 8'hCF, 8'hCD,
                                      8'hD4, 8'h5D, 8'h1F, 8'h50, 8'hDB};

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copy
    logic        last_echo;
    logic [15:0] pulse_ticks;
    logic        ranging;
    logic [13:0] shown_distance;
    logic [1:0]  scan_pos;
    logic [7:0]  seg_latch;
    logic [3:0]  enable_latch;
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [15:0] cfg_over;
    logic [15:0] cfg_timeout;

    out_item_t   pending_results[$];
    row_t        directed[$];
    bit          idling_on;
    int unsigned fail_count;
    int unsigned total_requests;
    int unsigned trigger_total;
    int unsigned store_total;
    int unsigned settings_applied;
    int unsigned cycle_count;
    int unsigned stall_left;

    echo_range_meter_with_digit_scan_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic in_item_t req(input bit echo, input bit t50, input bit t1);
        in_item_t rq;
        rq.echo_level = echo;
        rq.tick_50us  = t50;
        rq.tick_1ms   = t1;
        return rq;
    endfunction

    function automatic out_item_t res(input bit trig, input logic [7:0] seg,
                                      input logic [3:0] en, input logic [13:0] dist_val);
        out_item_t r;
        r.trigger_pulse  = trig;
        r.segment_bits   = seg;
        r.digit_enable_n = en;
        r.distance_value = dist_val;
        return r;
    endfunction

    function automatic logic [3:0] decimal_digit(input logic [13:0] value,
                                                 input logic [1:0] pos);
        int unsigned v;
        v = 32'(value);
        repeat (pos) v = v / 10;
        return 4'(v % 10);
    endfunction

    function automatic out_item_t range_meter_step(input in_item_t rq);
        out_item_t   r;
        int unsigned conv_dist;
        r = '0;
        if (rq.echo_level && !last_echo)
        begin
            pulse_ticks = '0;
            ranging     = 1'b0;
        end
        else if (!rq.echo_level && last_echo)
        begin
            if (pulse_ticks > cfg_min && pulse_ticks < cfg_max)
            begin
                conv_dist = 32'(pulse_ticks) * DIST_SCALE / SOUND_DIV;
                shown_distance = (conv_dist > OVERRANGE_CODE) ? OVERRANGE_CODE
                                                              : 14'(conv_dist);
                store_total++;
            end
            else if (pulse_ticks >= cfg_over)
            begin
                shown_distance = OVERRANGE_CODE;
                store_total++;
            end
            pulse_ticks = '0;
            ranging     = 1'b0;
        end
        last_echo = rq.echo_level;
        if (rq.tick_50us)
        begin
            if (pulse_ticks < COUNT_LIMIT)
                pulse_ticks = pulse_ticks + 16'd1;
            if (ranging && pulse_ticks > cfg_timeout)
                ranging = 1'b0;
        end
        if (rq.tick_1ms)
        begin
            scan_pos     = scan_pos + 2'd1;
            seg_latch    = GLYPHS[decimal_digit(shown_distance, scan_pos) * 8 +: 8];
            enable_latch = ~(4'b0001 << scan_pos);
        end
        // rearm whenever no measurement is pending
        if (!ranging)
        begin
            r.trigger_pulse = 1'b1;
            ranging = 1'b1;
            trigger_total++;
        end
        r.segment_bits   = seg_latch;
        r.digit_enable_n = enable_latch;
        r.distance_value = shown_distance;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_request(input in_item_t rq, input bit typed,
                                input out_item_t typed_want);
        int unsigned gap;
        out_item_t   predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = range_meter_step(rq);
        pending_results.push_back(typed ? typed_want : predicted);
        total_requests++;
        @(negedge clk);
    endtask

    task automatic send(input in_item_t rq);
        push_request(rq, 1'b0, '0);
    endtask

    // drop valid and hold until every result is back
    task automatic hold_off();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MIN_TICKS:       cfg_min     = value;
            REG_MAX_TICKS:       cfg_max     = value;
            REG_OVERRANGE_TICKS: cfg_over    = value;
            REG_TIMEOUT_TICKS:   cfg_timeout = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] min_v, input logic [15:0] max_v,
                                  input logic [15:0] over_v, input logic [15:0] tmo_v);
        hold_off();
        reg_write(REG_MIN_TICKS, min_v);
        reg_write(REG_MAX_TICKS, max_v);
        reg_write(REG_OVERRANGE_TICKS, over_v);
        reg_write(REG_TIMEOUT_TICKS, tmo_v);
        settings_applied++;
    endtask

    // low lead-in, then echo high for the given number of 50 us ticks, then fall
    task automatic run_pulse(input int unsigned ticks, input int unsigned lead);
        int unsigned tally;
        bit          t50;
        bit          first;
        repeat (lead) send(req(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
        tally = 0;
        first = 1'b1;
        while (first || tally < ticks)
        begin
            t50 = (tally < ticks) ? ($urandom_range(0, 7) != 0) : 1'b0;
            send(req(1'b1, t50, $urandom_range(0, 3) == 0));
            if (t50)
                tally++;
            first = 1'b0;
        end
        send(req(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
    endtask

    function automatic int unsigned pick_width();
        int w;
        case ($urandom_range(0, 8))
            0:       w = int'(cfg_min);
            1:       w = int'(cfg_min) + 1;
            2:       w = int'(cfg_max) - 1;
            3:       w = int'(cfg_max);
            4:       w = int'(cfg_over) - 1;
            5:       w = int'(cfg_over);
            6:       w = int'(cfg_timeout) + 1;
            default: w = $urandom_range(0, 40);
        endcase
        if (w < 0 || w > 1100)
            w = $urandom_range(0, 40);
        return w;
    endfunction

    task automatic run_phase(input int unsigned budget);
        int unsigned start;
        int unsigned lead;
        start = total_requests;
        while (total_requests - start < budget)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
            begin
                lead = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 4);
                run_pulse(pick_width(), lead);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send(req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: 0x%0h", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("trigger_pulse", 32'(want.trigger_pulse),
                            32'(out_data.trigger_pulse));
                check_field("segment_bits", 32'(want.segment_bits),
                            32'(out_data.segment_bits));
                check_field("digit_enable_n", 32'(want.digit_enable_n),
                            32'(out_data.digit_enable_n));
                check_field("distance_value", 32'(want.distance_value),
                            32'(out_data.distance_value));
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        out_ready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idling_on = 1'b1;
        fail_count = 0;
        total_requests = 0;
        trigger_total = 0;
        store_total = 0;
        settings_applied = 1;
        cycle_count = 0;
        stall_left = 0;

        last_echo      = 1'b0;
        pulse_ticks    = '0;
        ranging        = 1'b0;
        shown_distance = '0;
        scan_pos       = '0;
        seg_latch      = '0;
        enable_latch   = ENABLE_RST;
        cfg_min        = MIN_TICKS_RST;
        cfg_max        = MAX_TICKS_RST;
        cfg_over       = OVERRANGE_TICKS_RST;
        cfg_timeout    = TIMEOUT_TICKS_RST;

        // first trigger, idle hold, a full digit scan of zero, then short pulses
        directed.push_back('{req(0, 0, 0), 1'b1, res(1, 8'h00, 4'b1110, 14'd0)});
        directed.push_back('{req(0, 0, 0), 1'b1, res(0, 8'h00, 4'b1110, 14'd0)});
        directed.push_back('{req(0, 0, 1), 1'b1, res(0, 8'hDB, 4'b1101, 14'd0)});
        directed.push_back('{req(0, 0, 1), 1'b1, res(0, 8'hDB, 4'b1011, 14'd0)});
        directed.push_back('{req(0, 0, 1), 1'b1, res(0, 8'hDB, 4'b0111, 14'd0)});
        directed.push_back('{req(0, 0, 1), 1'b1, res(0, 8'hDB, 4'b1110, 14'd0)});
        directed.push_back('{req(1, 1, 0), 1'b1, res(1, 8'hDB, 4'b1110, 14'd0)});
        repeat (5) directed.push_back('{req(1, 1, 0), 1'b0, '0});
        directed.push_back('{req(0, 0, 1), 1'b0, '0});
        directed.push_back('{req(1, 1, 1), 1'b0, '0});
        directed.push_back('{req(1, 0, 0), 1'b0, '0});
        directed.push_back('{req(0, 0, 1), 1'b0, '0});
        directed.push_back('{req(0, 1, 1), 1'b0, '0});
        directed.push_back('{req(1, 1, 1), 1'b0, '0});
        directed.push_back('{req(1, 1, 0), 1'b0, '0});
        directed.push_back('{req(1, 1, 0), 1'b0, '0});
        directed.push_back('{req(1, 1, 1), 1'b0, '0});
        directed.push_back('{req(0, 1, 0), 1'b0, '0});
        directed.push_back('{req(0, 0, 1), 1'b0, '0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            push_request(directed[i].stim, directed[i].typed, directed[i].want);

        // widest window: short and mid-length stores
        idling_on = 1'b0;
        apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_pulse(10, 2);
        run_pulse(120, 2);
        run_pulse(10, 2);

        apply_settings(MIN_TICKS_RST, MAX_TICKS_RST, OVERRANGE_TICKS_RST, TIMEOUT_TICKS_RST);
        run_phase(100);
        apply_settings(16'd2, 16'd20, 16'd30, 16'd12);
        run_phase(100);
        apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd0);
        run_phase(100);
        apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        run_phase(100);
        apply_settings(16'd10, 16'd5, 16'd8, 16'd3);
        run_phase(100);
        apply_settings(16'($urandom_range(0, 15)), 16'($urandom_range(5, 60)),
                       16'($urandom_range(10, 80)), 16'($urandom_range(0, 40)));
        run_phase(100);

        hold_off();
        repeat (6) @(negedge clk);
        $display("Checked %0d requests over %0d register settings", total_requests,
                 settings_applied);
        $display("Predicted %0d triggers and %0d distance stores", trigger_total,
                 store_total);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
